[rtl/mtsm_pkg.sv]
// Package for the seed matcher: constants of the seeding recurrence,
// twist and tempering, the stage payload type and the register indexes.
// No dependencies.
package mtsm_pkg;

  localparam logic [31:0] INIT_MULT  = 32'h6c078965;
  localparam logic [31:0] TWIST_MAG  = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc60000;
  localparam logic [31:0] UPPER_MASK = 32'h80000000;
  localparam logic [31:0] LOWER_MASK = 32'h7fffffff;

  // Loop bound of the seeding recurrence: words 1 through InitEnd-1 are built.
  localparam int InitEnd  = 399;
  localparam int NumCells = InitEnd - 1;
  localparam int IdxW     = $clog2(InitEnd);

  // Position of the word at the input of the cell that also forms the twist operand y.
  localparam int GrabYCell = 1;

  typedef struct packed {
    logic [31:0] w;  // latest word of the recurrence
    logic [31:0] y;  // twist operand, built from words 1 and 2
  } mtsm_stage_t;

  typedef enum logic [0:0] {
    REG_TARGET_PID = 1'b0,
    REG_TARGET_TID = 1'b1
  } mtsm_reg_e;

endpackage

[rtl/mt19937_seed_first_output_matcher.sv]
// Seed matcher top level: chain of recurrence cells, twist/temper stage,
// target compare and an output register with one skid entry.
// Stages from an accepted seed to its result: 398 chain cells, one temper
// stage, one output register. Throughput: one seed per cycle while the skid entry is free.
// The chain advances as a whole; it freezes only while the skid entry is full.
// Reset clears all valid flags and both target registers to zero.
module mt19937_seed_first_output_matcher import mtsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [15:0] trainer_id_o,
  output logic [15:0] secret_id_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] target_pid_q;
  logic [15:0] target_tid_q;

  logic              en;
  logic [NumCells:0] chain_valid;
  mtsm_stage_t       chain_data [NumCells+1];

  logic        t_valid;
  logic [31:0] t;
  logic [15:0] want;
  logic        hit_new;
  logic        take;

  logic        out_valid_q;
  logic        out_hit_q;
  logic [31:0] out_t_q;
  logic        skid_valid_q;
  logic        skid_hit_q;
  logic [31:0] skid_t_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_pid_q <= '0;
      target_tid_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mtsm_reg_e'(cfg_index_i))
        REG_TARGET_PID: target_pid_q <= cfg_data_i;
        REG_TARGET_TID: target_tid_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // The whole chain moves together while the skid entry is free.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  assign chain_valid[0]  = in_valid_i && !in_stall_o;
  assign chain_data[0].w = seed_i;
  assign chain_data[0].y = '0;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    mtsm_init_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .idx_i    (IdxW'(k + 1)),
      .grab_y_i ((k + 1) == (GrabYCell + 1)),
      .valid_i  (chain_valid[k]),
      .data_i   (chain_data[k]),
      .valid_o  (chain_valid[k+1]),
      .data_o   (chain_data[k+1])
    );
  end

  mtsm_temper u_temper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[NumCells]),
    .data_i  (chain_data[NumCells]),
    .valid_o (t_valid),
    .t_o     (t)
  );

  // Only the top 13 secret id bits take part in the compare.
  assign want    = target_pid_q[31:16] ^ target_pid_q[15:0] ^ target_tid_q;
  assign hit_new = (t[15:0] == target_tid_q) && (t[31:19] == want[15:3]);
  assign take    = t_valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= take;
      end
    end else if (take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_hit_q <= skid_hit_q;
        out_t_q   <= skid_t_q;
      end else if (take) begin
        out_hit_q <= hit_new;
        out_t_q   <= t;
      end
    end else if (take) begin
      skid_hit_q <= hit_new;
      skid_t_q   <= t;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign trainer_id_o = out_t_q[15:0];
  assign secret_id_o  = out_t_q[31:16];

  // A beat parked in the skid entry implies the output register is full.
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  // The skid entry only fills when the output beat was held back.
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled without a stalled output beat");

  // A frozen chain must not move its last stage.
  a_frozen_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(t_valid) && $stable(t))
    else $error("temper stage changed while the chain was frozen");

endmodule

[rtl/mtsm_init_cell.sv]
// One cell of the seeding chain: builds the next recurrence word from the
// word handed over by its neighbor. Depends on mtsm_pkg.
module mtsm_init_cell import mtsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [IdxW-1:0]   idx_i,
  input  logic              grab_y_i,
  input  logic              valid_i,
  input  mtsm_stage_t       data_i,
  output logic              valid_o,
  output mtsm_stage_t       data_o
);

  logic [31:0] w_mix;
  logic [31:0] w_next;
  mtsm_stage_t data_d;
  mtsm_stage_t data_q;
  logic        valid_q;

  assign w_mix  = data_i.w ^ (data_i.w >> 30);
  assign w_next = 32'(w_mix * INIT_MULT) + 32'(idx_i);

  always_comb begin
    data_d.w = w_next;
    data_d.y = data_i.y;
    // The cell that makes word 2 sees word 1 at its input.
    if (grab_y_i) begin
      data_d.y = (data_i.w & UPPER_MASK) | (w_next & LOWER_MASK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/mtsm_temper.sv]
// Twist of word 1 and output tempering, one registered stage.
// Depends on mtsm_pkg.
module mtsm_temper import mtsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  mtsm_stage_t data_i,
  output logic        valid_o,
  output logic [31:0] t_o
);

  logic [31:0] x;
  logic [31:0] y1;
  logic [31:0] y2;
  logic [31:0] y3;
  logic [31:0] t_d;
  logic [31:0] t_q;
  logic        valid_q;

  assign x  = data_i.w ^ (data_i.y >> 1) ^ (data_i.y[0] ? TWIST_MAG : 32'h0);
  assign y1 = x ^ (x >> 11);
  assign y2 = y1 ^ ((y1 << 7) & TEMPER_B);
  assign y3 = y2 ^ ((y2 << 15) & TEMPER_C);
  assign t_d = y3 ^ (y3 >> 18);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  assign valid_o = valid_q;
  assign t_o     = t_q;

endmodule
